// ===== rtl/bba_pkg.sv =====
// Shared types, sizes and helper functions for the bitmap block allocator.
// No dependencies; imported by the allocator top and the remainder unit.
`timescale 1ns / 1ps

package bba_pkg;

    // Bitmap geometry
    localparam int CAPACITY  = 4096;
    localparam int WORD_W    = 64;
    localparam int MAP_WORDS = CAPACITY / WORD_W;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int WORD_AW   = $clog2(MAP_WORDS);
    localparam int IDX_W     = BIT_W + WORD_AW;
    localparam int CNT_W     = IDX_W + 1;
    localparam int RAND_W    = 32;
    localparam int REM_CNT_W = $clog2(RAND_W + 1);

    // Retry limits
    localparam int TRY_W      = 3;
    localparam int RAND_WORDS = 4;
    localparam int RSEL_W     = $clog2(RAND_WORDS);
    localparam logic [TRY_W-1:0] MAX_RETRIES = TRY_W'(4);

    localparam logic [CNT_W-1:0] CAPACITY_CNT = CNT_W'(CAPACITY);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'b1;

    // Request action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_MARK  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  block_index;
        logic [RAND_W-1:0] random_first;
        logic [RAND_W-1:0] random_second;
        logic [RAND_W-1:0] random_third;
        logic [RAND_W-1:0] random_fourth;
    } t_req;

    typedef struct packed {
        logic             success;
        logic [IDX_W-1:0] free_block;
        logic [CNT_W-1:0] used_count;
    } t_rsp;

    // Remainder unit status back to the sequencer
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] rem;
    } t_rem_rsp;

    // Index of the lowest set bit (zero when none is set)
    function automatic logic [BIT_W-1:0] f_first_one(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = BIT_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/bitmap_block_allocator.sv =====
// Bitmap block allocator: used-block bitmap with random-start free search.
// Mark: the word is checked in the mark state before the strobe is registered.
// A request failing its range or count check at once is answered without raising busy.
// Allocate: each random try runs the serial remainder, then scans 64 words at most;
// spent tries end in a scan from block zero. One request at a time; busy otherwise
// stays high until the result strobe; receivers cannot stall it. Reset: synchronous;
// the bitmap reads all clear at once via per-word valid flops, so no clearing pass.
`timescale 1ns / 1ps

module bitmap_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  bba_pkg::t_req                 i_req,
    output logic                          busy,
    output logic                          o_strobe,
    output bba_pkg::t_rsp                 o_rsp,
    input  logic                          i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bba_pkg::CNT_W-1:0]     i_cfg_wdata
);
    import bba_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_REM  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_MARK = 2'd3;

    // Control state
    logic [1:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_block_count;
    logic [TRY_W-1:0]   r_retry_limit;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [MAP_WORDS-1:0] r_valid, n_valid;
    logic               r_rd_vld;
    logic               r_rem_go, n_rem_go;
    logic               r_out_vld, n_out_vld;

    // Per-request working registers
    logic [CNT_W-1:0]   r_size, n_size;
    logic [TRY_W-1:0]   r_tries, n_tries;
    logic [RSEL_W-1:0]  r_try, n_try;
    logic               r_zero, n_zero;
    logic [WORD_AW-1:0] r_word, n_word;
    logic [BIT_W-1:0]   r_off, n_off;
    logic [RAND_W-1:0]  r_rand [RAND_WORDS];
    logic [RAND_W-1:0]  n_rand [RAND_WORDS];
    t_rsp               r_rsp, n_rsp;

    // Datapath
    t_rem_rsp           rem_rsp;
    logic [WORD_W-1:0]  ram_q;
    logic [WORD_W-1:0]  word_eff;
    logic [WORD_W-1:0]  free_mask;
    logic [IDX_W-1:0]   hit_pos;
    logic [CNT_W-1:0]   next_base;
    logic [CNT_W-1:0]   size_now;
    logic [TRY_W-1:0]   tries_now;
    logic               ram_we;
    logic [WORD_W-1:0]  ram_wdata;

    // Bitmap words: one read per cycle at the next word index
    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_word),
        .i_wdata (ram_wdata),
        .i_raddr (n_word),
        .o_rdata (ram_q)
    );

    bba_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_rem_go),
        .i_dividend (r_rand[r_try]),
        .i_divisor  (r_size),
        .o_rsp      (rem_rsp)
    );

    // Word as seen by the search: never-written words read as clear
    assign word_eff  = r_rd_vld ? ram_q : '0;
    assign free_mask = ~word_eff & ({WORD_W{1'b1}} << r_off);
    assign hit_pos   = {r_word, f_first_one(free_mask)};
    assign next_base = {({1'b0, r_word} + (WORD_AW + 1)'(1)), {BIT_W{1'b0}}};
    assign ram_wdata = word_eff | (WORD_W'(1) << r_off);

    // Effective size and try count from the configuration
    assign size_now  = (r_block_count > CAPACITY_CNT) ? CAPACITY_CNT : r_block_count;
    assign tries_now = (r_retry_limit == '0) ? TRY_W'(1) :
                       (r_retry_limit > MAX_RETRIES) ? MAX_RETRIES : r_retry_limit;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_valid   = r_valid;
        n_rem_go  = 1'b0;
        n_out_vld = 1'b0;
        n_size    = r_size;
        n_tries   = r_tries;
        n_try     = r_try;
        n_zero    = r_zero;
        n_word    = r_word;
        n_off     = r_off;
        n_rand    = r_rand;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_size    = size_now;
                    n_tries   = tries_now;
                    n_try     = '0;
                    n_zero    = 1'b0;
                    n_rand[0] = i_req.random_first;
                    n_rand[1] = i_req.random_second;
                    n_rand[2] = i_req.random_third;
                    n_rand[3] = i_req.random_fourth;
                    n_rsp.success    = 1'b0;
                    n_rsp.free_block = '0;
                    n_rsp.used_count = r_used;
                    if (i_req.action == ACT_MARK) begin
                        if ({1'b0, i_req.block_index} < size_now) begin
                            n_word  = i_req.block_index[IDX_W-1:BIT_W];
                            n_off   = i_req.block_index[BIT_W-1:0];
                            n_state = S_MARK;
                        end else begin
                            n_out_vld = 1'b1;
                        end
                    end else if (size_now != '0 && r_used < size_now) begin
                        n_rem_go = 1'b1;
                        n_state  = S_REM;
                    end else begin
                        n_out_vld = 1'b1;
                    end
                end
            end

            S_REM: begin
                if (rem_rsp.done) begin
                    n_word  = rem_rsp.rem[IDX_W-1:BIT_W];
                    n_off   = rem_rsp.rem[BIT_W-1:0];
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                if (free_mask != '0 && {1'b0, hit_pos} < r_size) begin
                    // free block found
                    n_rsp.success    = 1'b1;
                    n_rsp.free_block = hit_pos;
                    n_out_vld        = 1'b1;
                    n_state          = S_IDLE;
                end else if (free_mask == '0 && next_base < r_size) begin
                    // word full: move on to the next one
                    n_word = r_word + WORD_AW'(1);
                    n_off  = '0;
                end else if (r_zero) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end else if (TRY_W'({1'b0, r_try}) + TRY_W'(1) < r_tries) begin
                    n_try    = r_try + RSEL_W'(1);
                    n_rem_go = 1'b1;
                    n_state  = S_REM;
                end else begin
                    // random tries spent: scan from block zero
                    n_zero = 1'b1;
                    n_word = '0;
                    n_off  = '0;
                end
            end

            S_MARK: begin
                if (!word_eff[r_off]) begin
                    ram_we           = 1'b1;
                    n_valid[r_word]  = 1'b1;
                    n_used           = r_used + CNT_W'(1);
                    n_rsp.success    = 1'b1;
                    n_rsp.used_count = r_used + CNT_W'(1);
                end
                n_out_vld = 1'b1;
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_block_count <= CAPACITY_CNT;
            r_retry_limit <= MAX_RETRIES;
            r_used        <= '0;
            r_valid       <= '0;
            r_rd_vld      <= 1'b0;
            r_rem_go      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_valid   <= n_valid;
            r_rd_vld  <= r_valid[n_word];
            r_rem_go  <= n_rem_go;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLOCK_COUNT: r_block_count <= i_cfg_wdata;
                    CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_wdata[TRY_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_size  <= n_size;
        r_tries <= n_tries;
        r_try   <= n_try;
        r_zero  <= n_zero;
        r_word  <= n_word;
        r_off   <= n_off;
        r_rand  <= n_rand;
        r_rsp   <= n_rsp;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_out_vld;
    assign o_rsp    = r_rsp;

    // Checks
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CAPACITY_CNT)
        else $error("used count above capacity");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used == $past(r_used) || r_used == $past(r_used) + CNT_W'(1))
        else $error("used count moved by more than one");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_strobe)
        else $error("accepted request neither busy nor answered");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_rsp.success |-> o_rsp.free_block == '0)
        else $error("failed result carries a block index");

    a_rem_in_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_rsp.done |-> r_state == S_REM)
        else $error("remainder finished outside the wait state");

endmodule

// ===== rtl/bba_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bba_rem.sv =====
// Bit-serial restoring remainder unit: random word modulo the block count.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_rem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bba_pkg::RAND_W-1:0]  i_dividend,
    input  logic [bba_pkg::CNT_W-1:0]   i_divisor,
    output bba_pkg::t_rem_rsp           o_rsp
);
    import bba_pkg::*;

    logic [REM_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_done, n_done;
    logic [RAND_W-1:0]    r_dvd, n_dvd;
    logic [IDX_W-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]     trial;

    // One quotient bit per cycle, MSB first
    always_comb begin
        trial  = {r_rem, r_dvd[RAND_W-1]};
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_done = 1'b0;
        if (i_start) begin
            n_cnt = REM_CNT_W'(RAND_W);
            n_dvd = i_dividend;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - REM_CNT_W'(1);
            n_dvd  = {r_dvd[RAND_W-2:0], 1'b0};
            n_rem  = (trial >= i_divisor) ? IDX_W'(trial - i_divisor) : IDX_W'(trial);
            n_done = (r_cnt == REM_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule
